>>> rtl/tct_pkg.sv
// shared types, constants and helpers for the threshold contour tracer
`default_nettype none
package tct_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int CW = 8;              // signed neighbor coordinate width
    localparam int DIM_W = 7;           // width of the size registers

    localparam logic [1:0] REG_LEVEL  = 2'd0;
    localparam logic [1:0] REG_ABOVE  = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam logic [2:0] DIR_START = 3'd6;
    localparam logic [2:0] DIR_LEFT  = 3'd7;
    localparam logic [2:0] DIR_BACK  = 3'd6;
    localparam logic [2:0] DIR_TURN  = 3'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_LRD, S_LWR, S_CLR, S_SRD, S_SLD, S_STST,
        S_MRD, S_MWR, S_TISS, S_TCHK, S_TEND, S_ORD, S_OSET, S_OWAIT
    } t_state;

    typedef struct packed {
        logic signed [CW-1:0] nx;
        logic signed [CW-1:0] ny;
        logic                 inb;
    } t_nbr;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic signed [1:0] step_dx(input logic [2:0] d);
        logic signed [1:0] v;
        case (d) inside
            3'd0, 3'd1, 3'd7: v = 2'sd1;
            3'd2, 3'd6:       v = 2'sd0;
            default:          v = -2'sd1;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] step_dy(input logic [2:0] d);
        logic signed [1:0] v;
        case (d) inside
            [3'd1:3'd3]: v = -2'sd1;
            3'd0, 3'd4:  v = 2'sd0;
            default:     v = 2'sd1;
        endcase
        return v;
    endfunction

    // zero reads as one, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] mx);
        logic [DIM_W-1:0] r;
        if (v == '0) r = DIM_W'(1);
        else if (v > mx) r = mx;
        else r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/tct_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module tct_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [WIDTH-1:0]          i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/tct_nbr.sv
// neighbor coordinate and border test for one trace direction
`default_nettype none
module tct_nbr
    import tct_pkg::*;
#(
    parameter int XW = 6,
    parameter int YW = 6
) (
    input  wire  [XW-1:0]    i_cx,
    input  wire  [YW-1:0]    i_cy,
    input  wire  [2:0]       i_dir,
    input  wire  [DIM_W-1:0] i_w,
    input  wire  [DIM_W-1:0] i_h,
    output t_nbr             o_nbr
);
    logic signed [CW-1:0] w_nx;
    logic signed [CW-1:0] w_ny;

    assign w_nx = $signed(CW'(i_cx)) + CW'(step_dx(i_dir));
    assign w_ny = $signed(CW'(i_cy)) + CW'(step_dy(i_dir));

    always_comb begin
        o_nbr.nx  = w_nx;
        o_nbr.ny  = w_ny;
        o_nbr.inb = !w_nx[CW-1] && !w_ny[CW-1] &&
                    ($unsigned(w_nx) < CW'(i_w)) && ($unsigned(w_ny) < CW'(i_h));
    end
endmodule
`default_nettype wire

>>> rtl/tct_div.sv
// restoring divider, one quotient bit per cycle, splits a load position into row and column
`default_nettype none
module tct_div
    import tct_pkg::*;
#(
    parameter int NW = 13,
    parameter int DW = 7
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire  [NW-1:0] i_num,
    input  wire  [DW-1:0] i_den,
    output t_div_stat     o_stat,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);
    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [NW-1:0]   r_num;
    logic [DW-1:0]   r_den;
    logic [DW-1:0]   r_rem;
    logic [NW-1:0]   r_quo;
    logic [DW:0]     w_trial;
    logic            w_ge;

    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[NW-2:0], 1'b0};
                r_quo <= {r_quo[NW-2:0], w_ge};
                r_rem <= w_ge ? DW'(w_trial - {1'b0, r_den}) : DW'(w_trial);
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo = r_quo;
    assign o_rem = r_rem;
endmodule
`default_nettype wire

>>> rtl/threshold_contour_tracer.sv
// threshold contour tracer top level: pixel load, contour trace sequencer and row output
// Use: pixels of a frame arrive in raster order on the input channel
// (i_valid / o_stall). Each is compared to the level and stored as one bit.
// A pixel normally passes accept, row read and row write; when the frame
// width has changed since the load position was last split into row and
// column, the divider splits it anew before the row read.
// The beat carrying i_last_pixel starts the trace: the contour store is
// cleared, one row per cycle, then the image is scanned pixel by pixel,
// each row read first and read again after each trace, and each new
// boundary traced: every neighbor test uses the single image read port
// (issue, check) and every move adds a mark read, mark write and closing check.
// Then frame_height row words leave on the output channel (o_valid /
// i_stall), each read and set up once the one before is taken. A stalled word holds
// and the block waits; no new pixel is taken until the last row word leaves.
// Configuration writes are taken at any time but belong between frames.
// Reset returns the sizes to 64x64, level 0, above mode, load position 0;
// image contents are kept undefined until loaded.
`default_nettype none
module threshold_contour_tracer
    import tct_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [1:0]                   i_cfg_index,
    input  wire  [15:0]                  i_cfg_data,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  signed [15:0]           i_pixel,
    input  wire                          i_last_pixel,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [MAX_WIDTH-1:0]         o_row_mask,
    output logic [$clog2(MAX_HEIGHT)-1:0] o_row_index,
    output logic                         o_last_row
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SZW = 2 * DIM_W;
    localparam int MOVE_CAP = 8 * MAX_WIDTH * MAX_HEIGHT;
    localparam int MW = $clog2(MOVE_CAP + 1);

    t_state r_state, n_state;

    logic signed [15:0] r_level;
    logic               r_above;
    logic [DIM_W-1:0]   r_fw, r_fh;

    logic [AW-1:0]  r_pos, n_pos;
    logic [XW-1:0]  r_lx, n_lx;
    logic [YW-1:0]  r_ly, n_ly;
    logic           r_lvalid, n_lvalid;
    logic [DIM_W-1:0] r_lw, n_lw;
    logic           r_bit, n_bit;
    logic           r_last, n_last;
    logic [XW-1:0]  r_sx, n_sx;
    logic [YW-1:0]  r_sy, n_sy;
    logic [XW-1:0]  r_cx, n_cx;
    logic [YW-1:0]  r_cy, n_cy;
    logic [2:0]     r_dir, n_dir;
    logic [1:0]     r_t, n_t;
    logic [1:0]     r_k, n_k;
    logic [MW-1:0]  r_moves, n_moves;
    t_nbr           r_nb, n_nb;
    logic [MAX_WIDTH-1:0] r_irow, n_irow;
    logic [MAX_WIDTH-1:0] r_mrow, n_mrow;
    logic           r_mk_start, n_mk_start;
    logic [YW-1:0]  r_oy, n_oy;
    logic           n_valid;
    logic [MAX_WIDTH-1:0] n_row_mask;
    logic           n_last_row;

    logic [DIM_W-1:0] w_ew, w_eh;
    logic [SZW-1:0]   w_size;
    logic             w_thr;
    logic             w_need_div;
    logic             w_div_start;
    t_div_stat        w_div_stat;
    logic [AW-1:0]    w_quo;
    logic [DIM_W-1:0] w_rem;
    logic [2:0]       w_tdir;
    t_nbr             w_nbr;
    logic [MAX_WIDTH-1:0] w_wmask;

    logic             w_img_we;
    logic [YW-1:0]    w_img_waddr, w_img_raddr;
    logic [MAX_WIDTH-1:0] w_img_wdata, w_img_rdata;
    logic             w_msk_we;
    logic [YW-1:0]    w_msk_waddr, w_msk_raddr;
    logic [MAX_WIDTH-1:0] w_msk_wdata, w_msk_rdata;

    assign w_ew   = eff_dim(r_fw, DIM_W'(MAX_WIDTH));
    assign w_eh   = eff_dim(r_fh, DIM_W'(MAX_HEIGHT));
    assign w_size = SZW'(w_ew) * SZW'(w_eh);
    assign w_thr  = r_above ? (i_pixel > r_level) : (i_pixel < r_level);
    assign w_need_div = !(r_lvalid && (r_lw == w_ew)) && (r_pos != '0);

    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            w_wmask[i] = (i < int'(w_ew));
        end
    end

    always_comb begin
        case (r_t)
            2'd0:    w_tdir = r_dir + DIR_LEFT;
            2'd1:    w_tdir = r_dir;
            default: w_tdir = r_dir + 3'd1;
        endcase
    end

    tct_nbr #(.XW(XW), .YW(YW)) u_nbr (
        .i_cx  (r_cx),
        .i_cy  (r_cy),
        .i_dir (w_tdir),
        .i_w   (w_ew),
        .i_h   (w_eh),
        .o_nbr (w_nbr)
    );

    tct_div #(.NW(AW), .DW(DIM_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_pos),
        .i_den   (w_ew),
        .o_stat  (w_div_stat),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    tct_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_img (
        .i_clk   (i_clk),
        .i_we    (w_img_we),
        .i_waddr (w_img_waddr),
        .i_wdata (w_img_wdata),
        .i_raddr (w_img_raddr),
        .o_rdata (w_img_rdata)
    );

    tct_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_msk (
        .i_clk   (i_clk),
        .i_we    (w_msk_we),
        .i_waddr (w_msk_waddr),
        .i_wdata (w_msk_wdata),
        .i_raddr (w_msk_raddr),
        .o_rdata (w_msk_rdata)
    );

    assign o_stall = (r_state != S_IDLE);

    // memory port steering
    always_comb begin
        w_img_we    = (r_state == S_LWR);
        w_img_waddr = r_ly;
        w_img_wdata = (w_img_rdata & ~(MAX_WIDTH'(1) << r_lx)) |
                      (MAX_WIDTH'(r_bit) << r_lx);
        case (r_state)
            S_LRD:   w_img_raddr = r_ly;
            S_TISS:  w_img_raddr = w_nbr.ny[YW-1:0];
            default: w_img_raddr = r_sy;
        endcase
        w_msk_we    = (r_state == S_CLR) || (r_state == S_MWR);
        w_msk_waddr = (r_state == S_CLR) ? r_oy : r_cy;
        w_msk_wdata = (r_state == S_CLR) ? '0 :
                      (w_msk_rdata | (MAX_WIDTH'(1) << r_cx));
        case (r_state)
            S_MRD:   w_msk_raddr = r_cy;
            S_ORD:   w_msk_raddr = r_oy;
            default: w_msk_raddr = r_sy;
        endcase
    end

    always_comb begin
        logic left;
        logic hit;
        logic [MW-1:0] mv;
        n_state = r_state;
        n_pos = r_pos;   n_lx = r_lx;   n_ly = r_ly;
        n_lvalid = r_lvalid;  n_lw = r_lw;
        n_bit = r_bit;   n_last = r_last;
        n_sx = r_sx;     n_sy = r_sy;
        n_cx = r_cx;     n_cy = r_cy;   n_dir = r_dir;
        n_t = r_t;       n_k = r_k;     n_moves = r_moves;
        n_nb = r_nb;     n_irow = r_irow;  n_mrow = r_mrow;
        n_mk_start = r_mk_start;  n_oy = r_oy;
        n_valid = o_valid;
        n_row_mask = o_row_mask;
        n_last_row = o_last_row;
        w_div_start = 1'b0;
        left = (r_sx == '0) ? 1'b0 : r_irow[r_sx - XW'(1)];
        hit  = r_nb.inb && w_img_rdata[r_nb.nx[XW-1:0]];
        mv   = r_moves + MW'(1);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_bit  = w_thr;
                    n_last = i_last_pixel;
                    if (SZW'(r_pos) < w_size) begin
                        if (r_pos == '0) begin
                            n_lx = '0;
                            n_ly = '0;
                            n_lw = w_ew;
                            n_lvalid = 1'b1;
                            n_state = S_LRD;
                        end else if (w_need_div) begin
                            w_div_start = 1'b1;
                            n_state = S_DIV;
                        end else begin
                            n_state = S_LRD;
                        end
                    end else begin
                        n_pos = AW'(w_size);
                        n_lvalid = 1'b0;
                        n_oy = '0;
                        n_state = i_last_pixel ? S_CLR : S_IDLE;
                    end
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_lx = w_rem[XW-1:0];
                    n_ly = w_quo[YW-1:0];
                    n_lw = w_ew;
                    n_lvalid = 1'b1;
                    n_state = S_LRD;
                end
            end
            S_LRD: n_state = S_LWR;
            S_LWR: begin
                n_pos = r_pos + AW'(1);
                if (DIM_W'(r_lx) == w_ew - DIM_W'(1)) begin
                    n_lx = '0;
                    n_ly = r_ly + YW'(1);
                end else begin
                    n_lx = r_lx + XW'(1);
                end
                n_oy = '0;
                n_state = r_last ? S_CLR : S_IDLE;
            end
            S_CLR: begin
                if (DIM_W'(r_oy) == w_eh - DIM_W'(1)) begin
                    n_sx = '0;
                    n_sy = '0;
                    n_state = S_SRD;
                end else begin
                    n_oy = r_oy + YW'(1);
                end
            end
            S_SRD: n_state = S_SLD;
            S_SLD: begin
                n_irow = w_img_rdata;
                n_mrow = w_msk_rdata;
                n_state = S_STST;
            end
            S_STST: begin
                if (r_irow[r_sx] && !r_mrow[r_sx] && !left) begin
                    n_cx = r_sx;
                    n_cy = r_sy;
                    n_dir = DIR_START;
                    n_moves = '0;
                    n_mk_start = 1'b1;
                    n_state = S_MRD;
                end else if (DIM_W'(r_sx) == w_ew - DIM_W'(1)) begin
                    n_sx = '0;
                    if (DIM_W'(r_sy) == w_eh - DIM_W'(1)) begin
                        n_oy = '0;
                        n_state = S_ORD;
                    end else begin
                        n_sy = r_sy + YW'(1);
                        n_state = S_SRD;
                    end
                end else begin
                    n_sx = r_sx + XW'(1);
                end
            end
            S_MRD: n_state = S_MWR;
            S_MWR: begin
                if (r_mk_start) begin
                    n_mk_start = 1'b0;
                    n_t = '0;
                    n_k = '0;
                    n_state = S_TISS;
                end else begin
                    n_state = S_TEND;
                end
            end
            S_TISS: begin
                n_nb = w_nbr;
                n_state = S_TCHK;
            end
            S_TCHK: begin
                if (hit) begin
                    n_cx = r_nb.nx[XW-1:0];
                    n_cy = r_nb.ny[YW-1:0];
                    if (r_t == 2'd0) begin
                        n_dir = r_dir + DIR_BACK;
                    end
                    n_state = S_MRD;
                end else if (r_t != 2'd2) begin
                    n_t = r_t + 2'd1;
                    n_state = S_TISS;
                end else begin
                    n_dir = r_dir + DIR_TURN;
                    n_t = '0;
                    n_k = r_k + 2'd1;
                    n_state = (r_k == 2'd2) ? S_TEND : S_TISS;
                end
            end
            S_TEND: begin
                n_moves = mv;
                n_t = '0;
                n_k = '0;
                if (((r_cx == r_sx) && (r_cy == r_sy)) || (mv == MW'(MOVE_CAP))) begin
                    n_state = S_SRD;
                end else begin
                    n_state = S_TISS;
                end
            end
            S_ORD: n_state = S_OSET;
            S_OSET: begin
                n_row_mask = w_msk_rdata & w_wmask;
                n_last_row = (DIM_W'(r_oy) == w_eh - DIM_W'(1));
                n_valid = 1'b1;
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                if (!i_stall) begin
                    n_valid = 1'b0;
                    if (o_last_row) begin
                        n_pos = '0;
                        n_lvalid = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_oy = r_oy + YW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_level  <= '0;
            r_above  <= 1'b1;
            r_fw     <= DIM_W'(64);
            r_fh     <= DIM_W'(64);
            r_pos    <= '0;
            r_lvalid <= 1'b0;
            r_mk_start <= 1'b0;
            r_dir    <= DIR_START;
            r_t      <= '0;
            r_k      <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_lvalid <= n_lvalid;
            r_mk_start <= n_mk_start;
            r_dir    <= n_dir;
            r_t      <= n_t;
            r_k      <= n_k;
            o_valid  <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LEVEL:  r_level <= i_cfg_data;
                    REG_ABOVE:  r_above <= i_cfg_data[0];
                    REG_WIDTH:  r_fw    <= i_cfg_data[DIM_W-1:0];
                    REG_HEIGHT: r_fh    <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lx <= n_lx;   r_ly <= n_ly;   r_lw <= n_lw;
        r_bit <= n_bit; r_last <= n_last;
        r_sx <= n_sx;   r_sy <= n_sy;
        r_cx <= n_cx;   r_cy <= n_cy;
        r_moves <= n_moves;
        r_nb <= n_nb;
        r_irow <= n_irow;
        r_mrow <= n_mrow;
        r_oy <= n_oy;
        o_row_mask <= n_row_mask;
        o_last_row <= n_last_row;
    end

    assign o_row_index = r_oy;

    // a row word is only shown while waiting for the receiver
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OWAIT)
        else $error("row word valid outside output wait");

    // a new row word follows the mask read
    a_valid_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_OSET)
        else $error("row word raised without mask read");

    // the closing pixel always leads into the trace
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_last_pixel) |=> r_state != S_IDLE)
        else $error("last pixel did not start the trace");

    // neighbor test index stays within the three candidates
    a_test_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TCHK) |-> (r_t != 2'd3 && r_k != 2'd3))
        else $error("neighbor test index out of range");
endmodule
`default_nettype wire
